// File: rtl/fat_cluster_table_engine_macros.svh
// assertion macros for the cluster table engine
`ifndef FAT_CLUSTER_TABLE_ENGINE_MACROS_SVH
`define FAT_CLUSTER_TABLE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define FCTE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcte assertion failed");
// next-cycle implication, checked out of reset
`define FCTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcte assertion failed");
`else
`define FCTE_ASSERT_IMPL(lbl, ante, cons)
`define FCTE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/fcte_pkg.sv
// shared types and constants of the cluster table engine
`timescale 1ns / 1ps
`default_nettype none

package fcte_pkg;

  localparam int CmdW    = 3;
  localparam int LinkW   = 16;
  localparam int CountW  = 12;
  localparam int StatusW = 2;
  // compare width: holds any cluster number and the table size itself
  localparam int CmpW    = 17;

  localparam logic [LinkW-1:0]  LINK_FREE    = 16'h0000;
  localparam logic [LinkW-1:0]  LINK_EOC     = 16'hFFFF;
  localparam logic [LinkW-1:0]  LINK_END_MIN = 16'hFFF8;
  localparam logic [CountW-1:0] COUNT_RESET  = 12'd4094;

  typedef enum logic [CmdW-1:0] {
    CMD_READ       = 3'd0,
    CMD_WRITE      = 3'd1,
    CMD_ALLOC      = 3'd2,
    CMD_FREE       = 3'd3,
    CMD_FREE_CHAIN = 3'd4
  } fcte_cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_LOOP  = 2'd3
  } fcte_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_ALLOC,
    S_CHAIN,
    S_CHAIN_WAIT,
    S_RESP
  } fcte_state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } fcte_mem_ctl_t;

endpackage

`default_nettype wire

// File: rtl/fcte_table.sv
// link table memory: one write port, one read port with registered data
`timescale 1ns / 1ps
`default_nettype none

module fcte_table #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int AW            = 12
) (
  input  wire                      clk_i,
  input  fcte_pkg::fcte_mem_ctl_t  ctl_i,
  input  wire  [AW-1:0]            addr_i,
  input  wire  [fcte_pkg::LinkW-1:0] wdata_i,
  output logic [fcte_pkg::LinkW-1:0] rdata_o
);
  import fcte_pkg::*;

  logic [LinkW-1:0] mem [TABLE_ENTRIES];
  logic [LinkW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/fcte_seq.sv
// command sequencer: clearing pass, decode, allocate scan and chain walk
`timescale 1ns / 1ps
`default_nettype none
`include "fat_cluster_table_engine_macros.svh"

module fcte_seq #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int AW            = 12
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // command side
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire  [fcte_pkg::CmdW-1:0]  in_cmd_i,
  input  wire  [fcte_pkg::LinkW-1:0] in_cluster_i,
  input  wire  [fcte_pkg::LinkW-1:0] in_link_i,
  input  wire  [fcte_pkg::CountW-1:0] cluster_count_i,
  // table port
  output fcte_pkg::fcte_mem_ctl_t    mem_ctl_o,
  output logic [AW-1:0]              mem_addr_o,
  output logic [fcte_pkg::LinkW-1:0] mem_wdata_o,
  input  wire  [fcte_pkg::LinkW-1:0] mem_rdata_i,
  // response side
  output logic                       rsp_valid_o,
  input  wire                        rsp_ready_i,
  output logic [fcte_pkg::LinkW-1:0] rsp_value_o,
  output logic [fcte_pkg::StatusW-1:0] rsp_status_o
);
  import fcte_pkg::*;

  localparam logic [CmpW-1:0] TableSize = CmpW'(TABLE_ENTRIES);
  localparam logic [AW-1:0]   LastAddr  = AW'(TABLE_ENTRIES - 1);

  fcte_state_e        state_q, state_d;
  logic [CmdW-1:0]    cmd_q;
  logic [LinkW-1:0]   cur_q;
  logic [LinkW-1:0]   link_q;
  logic [CmpW-1:0]    scan_q;
  logic [AW-1:0]      chk_q;
  logic               pend_q;
  logic [CountW-1:0]  steps_q;
  logic [AW-1:0]      clr_q;
  logic [LinkW-1:0]   res_value_q;
  logic [StatusW-1:0] res_status_q;

  logic [CmpW-1:0] cur_ext;
  logic [CmpW-1:0] cc_plus2;
  logic [CmpW-1:0] scan_end;
  logic            cur_in_tbl;
  logic            cur_is_link;
  logic            free_ok;
  logic            scan_found;
  logic            scan_more;
  logic            loop_hit;
  logic            chain_go;

  // range checks on the current cluster and scan bounds
  always_comb begin
    cur_ext     = CmpW'(cur_q);
    cc_plus2    = CmpW'(cluster_count_i) + CmpW'(2);
    scan_end    = (cc_plus2 > TableSize) ? TableSize : cc_plus2;
    cur_in_tbl  = cur_ext < TableSize;
    cur_is_link = (cur_q >= 16'd2) && (cur_q < LINK_END_MIN);
    free_ok     = (cur_q >= 16'd2) && (cur_ext < cc_plus2) && cur_in_tbl;
    scan_found  = pend_q && (mem_rdata_i == LINK_FREE);
    scan_more   = scan_q < scan_end;
    loop_hit    = steps_q >= cluster_count_i;
    chain_go    = cur_is_link && cur_in_tbl && !loop_hit;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == LastAddr) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (cmd_q)
          CMD_READ:       state_d = cur_in_tbl ? S_READ_WAIT : S_RESP;
          CMD_ALLOC:      state_d = S_ALLOC;
          CMD_FREE_CHAIN: state_d = S_CHAIN;
          default:        state_d = S_RESP;
        endcase
      end
      S_READ_WAIT: state_d = S_RESP;
      S_ALLOC: begin
        if (scan_found || !scan_more) state_d = S_RESP;
      end
      S_CHAIN: begin
        state_d = chain_go ? S_CHAIN_WAIT : S_RESP;
      end
      S_CHAIN_WAIT: state_d = S_CHAIN;
      S_RESP: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // table accesses and handshake outputs
  always_comb begin
    mem_ctl_o   = '{rd_en: 1'b0, wr_en: 1'b0};
    mem_addr_o  = cur_q[AW-1:0];
    mem_wdata_o = LINK_FREE;
    unique case (state_q)
      S_CLEAR: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_addr_o      = clr_q;
      end
      S_DECODE: begin
        unique case (cmd_q)
          CMD_READ:  mem_ctl_o.rd_en = cur_in_tbl;
          CMD_WRITE: begin
            mem_ctl_o.wr_en = cur_in_tbl;
            mem_wdata_o     = link_q;
          end
          CMD_FREE:  mem_ctl_o.wr_en = free_ok;
          default:   mem_ctl_o = '{rd_en: 1'b0, wr_en: 1'b0};
        endcase
      end
      S_ALLOC: begin
        if (scan_found) begin
          mem_ctl_o.wr_en = 1'b1;
          mem_addr_o      = chk_q;
          mem_wdata_o     = LINK_EOC;
        end else if (scan_more) begin
          mem_ctl_o.rd_en = 1'b1;
          mem_addr_o      = scan_q[AW-1:0];
        end
      end
      S_CHAIN:      mem_ctl_o.rd_en = chain_go;
      S_CHAIN_WAIT: mem_ctl_o.wr_en = 1'b1;
      default:      mem_ctl_o = '{rd_en: 1'b0, wr_en: 1'b0};
    endcase
    in_ready_o   = (state_q == S_IDLE);
    rsp_valid_o  = (state_q == S_RESP);
    rsp_value_o  = res_value_q;
    rsp_status_o = res_status_q;
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == S_IDLE) begin
        pend_q <= 1'b0;
      end else if (state_q == S_ALLOC) begin
        pend_q <= !scan_found && scan_more;
      end
    end
  end

  // command operands, walk counters and result
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        cmd_q        <= in_cmd_i;
        cur_q        <= in_cluster_i;
        link_q       <= in_link_i;
        scan_q       <= CmpW'(2);
        steps_q      <= '0;
        res_value_q  <= LINK_FREE;
        res_status_q <= ST_OK;
      end
      S_DECODE: begin
        unique case (cmd_q)
          CMD_READ, CMD_WRITE: if (!cur_in_tbl) res_status_q <= ST_RANGE;
          CMD_FREE:            if (!free_ok) res_status_q <= ST_RANGE;
          CMD_ALLOC, CMD_FREE_CHAIN: res_status_q <= ST_OK;
          default:             res_status_q <= ST_RANGE;
        endcase
      end
      S_READ_WAIT: res_value_q <= mem_rdata_i;
      S_ALLOC: begin
        if (scan_found) begin
          res_value_q <= LinkW'(chk_q);
        end else if (scan_more) begin
          chk_q  <= scan_q[AW-1:0];
          scan_q <= scan_q + CmpW'(1);
        end else begin
          res_status_q <= ST_FULL;
        end
      end
      S_CHAIN: begin
        if (cur_is_link && !cur_in_tbl) begin
          res_status_q <= ST_RANGE;
        end else if (cur_is_link && loop_hit) begin
          res_status_q <= ST_LOOP;
        end
      end
      S_CHAIN_WAIT: begin
        cur_q   <= mem_rdata_i;
        steps_q <= steps_q + CountW'(1);
      end
      default: res_value_q <= res_value_q;
    endcase
  end

  `FCTE_ASSERT_IMPL(a_alloc_marks_eoc, state_q == S_ALLOC && mem_ctl_o.wr_en, mem_wdata_o == LINK_EOC)
  `FCTE_ASSERT_NEXT(a_chain_read_then_clear, state_q == S_CHAIN && mem_ctl_o.rd_en, state_q == S_CHAIN_WAIT)
  `FCTE_ASSERT_IMPL(a_clear_writes_zero, state_q == S_CLEAR, mem_ctl_o.wr_en && !mem_ctl_o.rd_en && mem_wdata_o == LINK_FREE)
  `FCTE_ASSERT_IMPL(a_idle_no_access, state_q == S_IDLE, !mem_ctl_o.rd_en && !mem_ctl_o.wr_en)

endmodule

`default_nettype wire

// File: rtl/fat_cluster_table_engine.sv
// top level of the cluster table engine: config register, sequencer, table, output register
//
// channel   dir  tdata fields (low bit up)                 tuser
// s_axis    in   cluster[15:0], link_value[31:16]          cmd[2:0]
// m_axis    out  result_value[15:0], status[17:16], pad    -
// cfg       in   cluster_count[11:0] on cfg_we_i           -
//
// read passes decode, read wait and response; write and free pass decode and response;
// allocate reads entries from cluster 2 in turn, free chain reads and clears each link;
// the single table port and its registered read data set this order
// after reset a clearing pass writes every table entry free while s_axis_tready is low
// a finished result sits in the output register while the next command is taken;
// the sequencer holds in its response state while that register is full and stalled
`timescale 1ns / 1ps
`default_nettype none

module fat_cluster_table_engine #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // cluster[15:0], link_value[31:16]
  input  wire  [2:0]  s_axis_tuser,   // cmd[2:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // result_value[15:0], status[17:16], zero[23:18]
  input  wire         cfg_we_i,
  input  wire  [11:0] cfg_wdata_i
);
  import fcte_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [CountW-1:0]  cluster_count_q;
  fcte_mem_ctl_t      mem_ctl;
  logic [AW-1:0]      mem_addr;
  logic [LinkW-1:0]   mem_wdata;
  logic [LinkW-1:0]   mem_rdata;
  logic               rsp_valid;
  logic               rsp_ready;
  logic [LinkW-1:0]   rsp_value;
  logic [StatusW-1:0] rsp_status;
  logic               out_valid_q;
  logic [LinkW-1:0]   out_value_q;
  logic [StatusW-1:0] out_status_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      cluster_count_q <= cfg_wdata_i;
    end
  end

  fcte_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_cmd_i        (s_axis_tuser),
    .in_cluster_i    (s_axis_tdata[15:0]),
    .in_link_i       (s_axis_tdata[31:16]),
    .cluster_count_i (cluster_count_q),
    .mem_ctl_o       (mem_ctl),
    .mem_addr_o      (mem_addr),
    .mem_wdata_o     (mem_wdata),
    .mem_rdata_i     (mem_rdata),
    .rsp_valid_o     (rsp_valid),
    .rsp_ready_i     (rsp_ready),
    .rsp_value_o     (rsp_value),
    .rsp_status_o    (rsp_status)
  );

  fcte_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_table (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // output register, loads when empty or being drained
  assign rsp_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_value_q  <= rsp_value;
      out_status_q <= rsp_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_status_q, out_value_q};

endmodule

`default_nettype wire
